// File: hdl/ntstg_pkg.sv
// Shared types, note table and rounding helper for the saw/triangle generator.
package ntstg_pkg;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_KNOB = 1'b1
  } item_kind_e;

  localparam int unsigned PeriodWidth = 7;
  localparam int unsigned StepWidth   = 10;
  localparam int unsigned AccWidth    = 16;
  localparam int unsigned LevelWidth  = 8;
  localparam int unsigned NoteCount   = 7;

  localparam logic [AccWidth-1:0]   RoundBit = 16'h0040;
  localparam logic [LevelWidth-1:0] LevelMax = 8'd255;

  typedef struct packed {
    logic [PeriodWidth-1:0] period;
    logic [StepWidth-1:0]   step;
  } note_t;

  // Band 0 covers readings 32..63, band 6 covers 224..255.
  localparam logic [PeriodWidth-1:0] NotePeriod [NoteCount] = '{
    7'd84, 7'd70, 7'd63, 7'd56, 7'd47, 7'd41, 7'd35
  };

  // Steps in 3.7 fixed point.
  localparam logic [StepWidth-1:0] NoteStep [NoteCount] = '{
    {3'd3, 7'b0000100}, {3'd3, 7'b1010010}, {3'd4, 7'b0000110}, {3'd4, 7'b1000110},
    {3'd5, 7'b0110110}, {3'd6, 7'b0011100}, {3'd7, 7'b0100100}
  };

  // The caller guarantees that the top three bits of the reading are nonzero.
  function automatic note_t note_lookup(input logic [7:0] reading);
    logic [2:0] band;
    note_t      note;
    band        = reading[7:5] - 3'd1;
    note.period = NotePeriod[band];
    note.step   = NoteStep[band];
    return note;
  endfunction

  // Round at bit 6 to an 8-bit level and saturate.
  function automatic logic [LevelWidth-1:0] round_level(input logic [AccWidth-1:0] acc);
    logic [9:0] sum;
    sum = {1'b0, acc[AccWidth-1:7]} + {9'd0, |(acc & RoundBit)};
    return (sum > {2'b00, LevelMax}) ? LevelMax : sum[LevelWidth-1:0];
  endfunction

endpackage

// File: hdl/ntstg_core.sv
// Oscillator state and per-item update for the saw/triangle generator.
module ntstg_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  ntstg_pkg::item_kind_e            kind_i,
  input  logic [7:0]                       knob_value_i,
  output logic [ntstg_pkg::LevelWidth-1:0] saw_level_o,
  output logic [ntstg_pkg::LevelWidth-1:0] tri_level_o,
  output logic                             running_o
);

  logic [ntstg_pkg::PeriodWidth-1:0] period_q, period_d;
  logic [ntstg_pkg::StepWidth-1:0]   step_q, step_d;
  logic [ntstg_pkg::PeriodWidth-1:0] count_q, count_d;
  logic [ntstg_pkg::AccWidth-1:0]    saw_acc_q, saw_acc_d;
  logic [ntstg_pkg::AccWidth-1:0]    tri_acc_q, tri_acc_d;
  logic                              falling_q, falling_d;
  logic                              active_q, active_d;
  logic [ntstg_pkg::LevelWidth-1:0]  saw_out_q, saw_out_d;
  logic [ntstg_pkg::LevelWidth-1:0]  tri_out_q, tri_out_d;

  ntstg_pkg::note_t                  note;
  logic [ntstg_pkg::AccWidth-1:0]    step_ext;
  logic [ntstg_pkg::AccWidth-1:0]    saw_sum;
  logic [ntstg_pkg::AccWidth-1:0]    tri_sum;
  logic [ntstg_pkg::PeriodWidth-1:0] count_inc;

  assign note      = ntstg_pkg::note_lookup(knob_value_i);
  assign step_ext  = {{(ntstg_pkg::AccWidth - ntstg_pkg::StepWidth){1'b0}}, step_q};
  assign saw_sum   = saw_acc_q + step_ext;
  assign tri_sum   = falling_q ? (tri_acc_q - step_ext) : (tri_acc_q + step_ext);
  assign count_inc = count_q + 7'd1;

  always_comb begin
    period_d  = period_q;
    step_d    = step_q;
    count_d   = count_q;
    saw_acc_d = saw_acc_q;
    tri_acc_d = tri_acc_q;
    falling_d = falling_q;
    active_d  = active_q;
    saw_out_d = saw_out_q;
    tri_out_d = tri_out_q;
    if (step_i) begin
      case (kind_i)
        ntstg_pkg::KIND_KNOB: begin
          if (knob_value_i[7:5] == 3'd0) begin
            // Stop reading.
            active_d  = 1'b0;
            period_d  = '0;
            step_d    = '0;
            saw_out_d = '0;
            tri_out_d = '0;
          end else if (note.period != period_q) begin
            count_d   = '0;
            falling_d = 1'b0;
            period_d  = note.period;
            step_d    = note.step;
            active_d  = 1'b1;
          end
        end
        ntstg_pkg::KIND_TICK: begin
          if (active_q) begin
            if (count_q == '0) begin
              saw_acc_d = '0;
              saw_out_d = '0;
              if (!falling_q) begin
                tri_acc_d = '0;
                tri_out_d = '0;
              end else begin
                tri_out_d = ntstg_pkg::round_level(tri_acc_q);
              end
            end else if (count_q <= period_q) begin
              saw_acc_d = saw_sum;
              saw_out_d = ntstg_pkg::round_level(saw_sum);
              tri_acc_d = tri_sum;
              tri_out_d = ntstg_pkg::round_level(tri_sum);
            end
            if (count_inc > period_q) begin
              count_d   = '0;
              falling_d = ~falling_q;
            end else begin
              count_d = count_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= '0;
      step_q    <= '0;
      count_q   <= '0;
      saw_acc_q <= '0;
      tri_acc_q <= '0;
      falling_q <= 1'b0;
      active_q  <= 1'b0;
      saw_out_q <= '0;
      tri_out_q <= '0;
    end else begin
      period_q  <= period_d;
      step_q    <= step_d;
      count_q   <= count_d;
      saw_acc_q <= saw_acc_d;
      tri_acc_q <= tri_acc_d;
      falling_q <= falling_d;
      active_q  <= active_d;
      saw_out_q <= saw_out_d;
      tri_out_q <= tri_out_d;
    end
  end

  assign saw_level_o = saw_out_q;
  assign tri_level_o = tri_out_q;
  assign running_o   = active_q;

endmodule

// File: hdl/note_table_saw_triangle_generator.sv
// Top level of the knob-tuned sawtooth and triangle generator.
//
// Each input item is either a sample tick (kind_i = 0) or a frequency knob
// reading (kind_i = 1, upper eight ADC bits on knob_value_i). Readings pick one
// of seven pentatonic notes, each with a period count and a 3.7 fixed-point
// step; a reading below 32 stops the oscillator and drives both levels to
// zero. Every item produces exactly one result item carrying the current
// sawtooth level, triangle level and running flag. The block takes one item
// per clock while the consumer does not stall: an item is captured in an input
// register; when it moves on, the oscillator state and the result are updated
// together by one add or subtract per accumulator, a rounding step and a
// compare against the period. The result is presented from the oscillator
// registers, which follow the input register. The oscillator state registers
// double as the result register, so the input side keeps accepting while the
// result side flows; when the consumer stalls, the captured item waits and the
// input stalls only once the input register is also full.
module note_table_saw_triangle_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [7:0]                       knob_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ntstg_pkg::LevelWidth-1:0] saw_level_o,
  output logic [ntstg_pkg::LevelWidth-1:0] tri_level_o,
  output logic                             running_o
);

  // Input register stage.
  logic                  in_full_q, in_full_d;
  ntstg_pkg::item_kind_e kind_q;
  logic [7:0]            knob_q;

  // Result valid flag; the levels live in the core.
  logic out_valid_q, out_valid_d;

  logic in_accept;
  logic result_ready;
  logic advance;

  // The result slot can take a new item when it is empty or being drained.
  assign result_ready = !out_valid_q || !out_stall_i;
  // The captured item moves into the oscillator when the result slot is free.
  assign advance      = in_full_q && result_ready;
  assign in_stall_o   = in_full_q && !result_ready;
  assign in_accept    = in_valid_i && !in_stall_o;

  always_comb begin
    in_full_d = in_full_q;
    if (in_accept) begin
      in_full_d = 1'b1;
    end else if (advance) begin
      in_full_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= ntstg_pkg::item_kind_e'(kind_i);
      knob_q <= knob_value_i;
    end
  end

  ntstg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .kind_i       (kind_q),
    .knob_value_i (knob_q),
    .saw_level_o  (saw_level_o),
    .tri_level_o  (tri_level_o),
    .running_o    (running_o)
  );

  assign out_valid_o = out_valid_q;

  // A stopped oscillator always shows zero levels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_o |-> (saw_level_o == '0) && (tri_level_o == '0))
    else $error("levels nonzero while stopped");

  // The input only stalls when a captured item is blocked by a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_full_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A blocked captured item is not lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_full_q && !result_ready |=> in_full_q)
    else $error("captured item dropped while blocked");

  // A result slot that moves an item forward holds a valid result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced item did not produce a result");

endmodule
